>>> sv/lsdd_pkg.sv
// ----------------------------------------------------------------------------
// LiDAR sector dropout detector package
// Shared constants, payload types, state encodings and small helper functions.
// ----------------------------------------------------------------------------
package lsdd_pkg;

  localparam int SECTORS      = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int SECT_W       = $clog2(SECTORS);
  localparam int KW           = SECT_W + 1;
  localparam int HALF         = (SECTORS + 1) / 2;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 16;
  localparam int TOT_W        = 20;
  localparam int MAP_W        = 20;
  localparam int COORD_W      = 16;
  localparam int CORD_W       = 36;
  localparam int ACC_W        = 32;
  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = 4;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int RATIO_W      = 9;
  localparam int THR_W        = 7;
  localparam int COV_W        = 9;
  localparam int QUOT_W       = 8;
  localparam int DIVC_W       = 4;
  localparam int RM_W         = CNT_W + RATIO_W;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_EOF   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 2'd2;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [MAP_W-1:0]          map_count;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   min_points;
    logic [RATIO_W-1:0] ratio;
    logic [THR_W-1:0]   gap_thr;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] sector_index;
    logic             sector_state;
    logic [COV_W-1:0] coverage_q8;
    logic [CNT_W-1:0] sector_points;
    logic             frame_incomplete;
    logic             front_blind;
    logic             rear_blind;
    logic [TOT_W-1:0] frame_points;
    logic [MAP_W-1:0] map_points;
    logic             last_sector;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_BIN_RD, ST_BIN_WR, ST_EOF_SETUP, ST_CHK_RD, ST_CHK_EV,
    ST_SCAN, ST_DECIDE, ST_EM_RD, ST_EM_DIV, ST_EM_OUT
  } frame_state_t;

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_FIN} cord_state_t;

  // Front hemisphere: sector center within +-pi/2.
  function automatic logic is_front(logic [SECT_W-1:0] s);
    int d;
    d = 4 * int'(s) + 2 - 2 * SECTORS;
    if (d < 0) d = -d;
    return d <= SECTORS;
  endfunction

  // Position of a sector in the rear scan order, which starts at sector HALF.
  function automatic logic [KW-1:0] rear_pos(logic [SECT_W-1:0] s);
    logic [KW-1:0] se;
    se = KW'(s);
    if (se >= KW'(HALF)) return se - KW'(HALF);
    return se + KW'(SECTORS - HALF);
  endfunction

  // Sector visited at step k of the rear scan.
  function automatic logic [SECT_W-1:0] rear_sector(logic [KW-1:0] k);
    logic [KW:0] t;
    t = {1'b0, k} + (KW+1)'(HALF);
    if (t >= (KW+1)'(SECTORS)) t = t - (KW+1)'(SECTORS);
    return t[SECT_W-1:0];
  endfunction

  // atan(2^-i) in 2^-32 turn units.
  function automatic logic [ACC_W-1:0] atan_lut(logic [ITER_W-1:0] i);
    logic [ACC_W-1:0] v;
    case (i)
      4'd0:  v = 32'h2000_0000;
      4'd1:  v = 32'h12E4_051E;
      4'd2:  v = 32'h09FB_385B;
      4'd3:  v = 32'h0511_11D4;
      4'd4:  v = 32'h028B_0D43;
      4'd5:  v = 32'h0145_D7E1;
      4'd6:  v = 32'h00A2_F61E;
      4'd7:  v = 32'h0051_7C55;
      4'd8:  v = 32'h0028_BE53;
      4'd9:  v = 32'h0014_5F2F;
      4'd10: v = 32'h000A_2F98;
      4'd11: v = 32'h0005_17CC;
      4'd12: v = 32'h0002_8BE6;
      4'd13: v = 32'h0001_45F3;
      4'd14: v = 32'h0000_A2FA;
      default: v = 32'h0000_517D;
    endcase
    return v;
  endfunction

endpackage

>>> sv/lidar_sector_dropout_detector.sv
// ----------------------------------------------------------------------------
// LiDAR sector dropout detector
// Bins planar points by bearing and reports per-sector coverage and dropouts.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one item per
// transfer. An item with opcode zero is a point; its bearing is found by a
// 16-iteration CORDIC and the point is counted in one of SECTORS sectors.
// An item with opcode one ends the frame: the block then emits SECTORS
// results on the output channel (out_valid / out_stall), sector zero first,
// with last_sector set on the final one, and clears all counters.
// A two-entry queue sits in front of the frame engine, so up to two items
// are taken while the engine is busy or the output is stalled.
// A point occupies the engine through the CORDIC iterations and a memory
// read-modify-write. An end of frame runs a check pass and two hemisphere
// scans over the sector memory, then an 8-step coverage division per sector.
// A stalled output holds its result and the engine waits on it.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while the
// block is idle. Reset (rst_n low, synchronous) restores the default
// registers and empties the frame; the sector memory needs no clearing pass.
// ----------------------------------------------------------------------------
module lidar_sector_dropout_detector import lsdd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic [MAP_W-1:0]          in_map_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          out_sector_index,
  output logic                      out_sector_state,
  output logic [COV_W-1:0]          out_coverage_q8,
  output logic [CNT_W-1:0]          out_sector_points,
  output logic                      out_frame_incomplete,
  output logic                      out_front_blind,
  output logic                      out_rear_blind,
  output logic [TOT_W-1:0]          out_frame_points,
  output logic [MAP_W-1:0]          out_map_points,
  output logic                      out_last_sector,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  cfg_t    cfg_r;
  item_t   in_item, q_item;
  logic    q_valid, q_pop;
  result_t res;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_points <= CNT_W'(10);
      cfg_r.ratio      <= RATIO_W'(128);
      cfg_r.gap_thr    <= THR_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_POINTS:    cfg_r.min_points <= cfg_wdata;
        CFG_PARTIAL_RATIO: cfg_r.ratio      <= cfg_wdata[RATIO_W-1:0];
        CFG_GAP_THRESHOLD: cfg_r.gap_thr    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.opcode    = in_opcode;
  assign in_item.point_x   = in_point_x;
  assign in_item.point_y   = in_point_y;
  assign in_item.map_count = in_map_count;

  lsdd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_stall (in_stall),
    .wr_item  (in_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  lsdd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_res   (res),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  assign out_sector_index     = res.sector_index;
  assign out_sector_state     = res.sector_state;
  assign out_coverage_q8      = res.coverage_q8;
  assign out_sector_points    = res.sector_points;
  assign out_frame_incomplete = res.frame_incomplete;
  assign out_front_blind      = res.front_blind;
  assign out_rear_blind       = res.rear_blind;
  assign out_frame_points     = res.frame_points;
  assign out_map_points       = res.map_points;
  assign out_last_sector      = res.last_sector;

endmodule

>>> sv/lsdd_queue.sv
// ----------------------------------------------------------------------------
// LiDAR sector dropout detector input queue
// Two-entry queue that decouples input acceptance from frame processing.
// ----------------------------------------------------------------------------
module lsdd_queue import lsdd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_pop,
  output item_t rd_item
);

  item_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]    count_r;
  logic                push, pop;

  assign wr_stall = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> sv/lsdd_cordic.sv
// ----------------------------------------------------------------------------
// LiDAR sector dropout detector angle unit
// Iterative vectoring CORDIC, one iteration per cycle, giving the sector.
// ----------------------------------------------------------------------------
module lsdd_cordic import lsdd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  output logic                      done,
  output logic [SECT_W-1:0]         sector
);

  localparam int PROD_W = ANGLE_BITS + KW;

  cord_state_t              state_r, state_nxt;
  logic signed [CORD_W-1:0] xr_r, yr_r, xs, ys, dx, dy;
  logic [ACC_W-1:0]         acc_r, u;
  logic [ITER_W-1:0]        it_r;
  logic                     yzero_r, xneg_r, ypos_r, yneg_r;
  logic [SECT_W-1:0]        sector_r;
  logic [ANGLE_BITS-1:0]    b;
  logic [PROD_W-1:0]        prod;
  logic [KW-1:0]            s_raw;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (start) state_nxt = C_ITER;
      C_ITER:  if (it_r == ITER_W'(CORDIC_ITERS - 1)) state_nxt = C_FIN;
      C_FIN:   state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    done   = (state_r == C_FIN);
    sector = sector_r;
  end

  assign xs = {{(CORD_W-COORD_W-16){x[COORD_W-1]}}, x, 16'b0};
  assign ys = {{(CORD_W-COORD_W-16){y[COORD_W-1]}}, y, 16'b0};
  assign dx = yr_r >>> it_r;
  assign dy = xr_r >>> it_r;

  // Final angle plus pi, with the axis case and the half-plane guard.
  always_comb begin
    u = acc_r + 32'h8000_0000;
    if (yzero_r) begin
      u = xneg_r ? 32'hFFFF_FFFF : 32'h8000_0000;
    end else if (ypos_r && u <= 32'h8000_0000) begin
      u = (u < 32'h4000_0000) ? 32'hFFFF_FFFF : 32'h8000_0001;
    end else if (yneg_r && u >= 32'h8000_0000) begin
      u = (u >= 32'hC000_0000) ? 32'h0000_0000 : 32'h7FFF_FFFF;
    end
    b     = u[ACC_W-1 -: ANGLE_BITS];
    prod  = PROD_W'(b) * PROD_W'(SECTORS);
    s_raw = prod[ANGLE_BITS +: KW];
    if (s_raw >= KW'(SECTORS)) s_raw = KW'(SECTORS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          it_r    <= '0;
          yzero_r <= (y == '0);
          xneg_r  <= x[COORD_W-1];
          ypos_r  <= !y[COORD_W-1] && (y != '0);
          yneg_r  <= y[COORD_W-1];
          if (x[COORD_W-1]) begin
            xr_r  <= -xs;
            yr_r  <= -ys;
            acc_r <= 32'h8000_0000;
          end else begin
            xr_r  <= xs;
            yr_r  <= ys;
            acc_r <= '0;
          end
        end
      end
      C_ITER: begin
        it_r <= it_r + 1'b1;
        if (!yr_r[CORD_W-1]) begin
          xr_r  <= xr_r + dx;
          yr_r  <= yr_r - dy;
          acc_r <= acc_r + atan_lut(it_r);
        end else begin
          xr_r  <= xr_r - dx;
          yr_r  <= yr_r + dy;
          acc_r <= acc_r - atan_lut(it_r);
        end
      end
      C_FIN: sector_r <= s_raw[SECT_W-1:0];
      default: ;
    endcase
  end

endmodule

>>> sv/lsdd_frame.sv
// ----------------------------------------------------------------------------
// LiDAR sector dropout detector frame engine
// Bins points into the sector memory and runs the end-of-frame passes.
// ----------------------------------------------------------------------------
module lsdd_frame import lsdd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   q_item,
  input  logic    q_valid,
  output logic    q_pop,
  input  cfg_t    cfg,
  output result_t out_res,
  output logic    out_valid,
  input  logic    out_stall
);

  frame_state_t      state_r, state_nxt;
  logic [KW-1:0]     k_r;
  logic              k_last;

  logic              cord_start, cord_done;
  logic [SECT_W-1:0] cord_sector;

  logic [CNT_W-1:0]  bins_mem [SECTORS];
  logic [CNT_W-1:0]  rd_data_r, cnt_rd, cnt_inc, cmin;
  logic              rd_vld_r;
  logic [SECTORS-1:0] valid_r;
  logic [SECT_W-1:0] rd_addr;
  logic              wr_en;

  logic [TOT_W-1:0]  total_r, front_r, rear_r;
  logic [CNT_W-1:0]  m_r, m_eff;
  logic [RM_W-1:0]   rm_r;
  logic              partial_r, empty_r, fdrop_r, rdrop_r;
  logic [MAP_W-1:0]  map_r;

  logic              hemi_front_r;
  logic [KW-1:0]     cur_r, best_r, start_r, fbest_r, fstart_r;
  logic [KW-1:0]     cur_nxt, best_nxt, start_nxt;
  logic [SECT_W-1:0] s_scan, e_sec;
  logic              incl;

  logic [DIVC_W-1:0] div_cnt_r;
  logic [CNT_W:0]    rem_r, rem2;
  logic [QUOT_W-1:0] quot_r;
  logic              sat_r, fdrop, rdrop, in_f, in_r, slot_free;
  logic [CNT_W-1:0]  cnt_cur_r;
  logic [KW-1:0]     e_pos;
  logic              e_front;

  result_t           out_res_r;
  logic              out_valid_r;

  lsdd_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_start),
    .x      (q_item.point_x),
    .y      (q_item.point_y),
    .done   (cord_done),
    .sector (cord_sector)
  );

  assign k_last    = (k_r == KW'(SECTORS - 1));
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign m_eff     = (cfg.min_points == '0) ? CNT_W'(1) : cfg.min_points;
  assign cnt_rd    = rd_vld_r ? rd_data_r : '0;
  assign cnt_inc   = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
  assign cmin      = (cnt_rd < m_r) ? cnt_rd : m_r;
  assign rem2      = {rem_r[CNT_W-1:0], 1'b0};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (q_valid) state_nxt = (q_item.opcode == OP_EOF) ? ST_EOF_SETUP
                                                                       : ST_ANGLE;
      ST_ANGLE:     if (cord_done) state_nxt = ST_BIN_RD;
      ST_BIN_RD:    state_nxt = ST_BIN_WR;
      ST_BIN_WR:    state_nxt = ST_IDLE;
      ST_EOF_SETUP: state_nxt = ST_CHK_RD;
      ST_CHK_RD:    state_nxt = ST_CHK_EV;
      ST_CHK_EV:    if (k_last) state_nxt = ST_SCAN; else state_nxt = ST_CHK_RD;
      ST_SCAN:      if (k_last && !hemi_front_r) state_nxt = ST_DECIDE;
      ST_DECIDE:    state_nxt = ST_EM_RD;
      ST_EM_RD:     state_nxt = ST_EM_DIV;
      ST_EM_DIV:    if (div_cnt_r == DIVC_W'(QUOT_W)) state_nxt = ST_EM_OUT;
      ST_EM_OUT:    if (slot_free) state_nxt = k_last ? ST_IDLE : ST_EM_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop      = (state_r == ST_IDLE) && q_valid;
    cord_start = (state_r == ST_IDLE) && q_valid && (q_item.opcode == OP_POINT);
    wr_en      = (state_r == ST_BIN_WR);
    rd_addr    = (state_r == ST_BIN_RD || state_r == ST_BIN_WR) ? cord_sector
                                                                 : k_r[SECT_W-1:0];
  end

  // Run tracking over the current hemisphere's scan order.
  always_comb begin
    s_scan    = hemi_front_r ? k_r[SECT_W-1:0] : rear_sector(k_r);
    incl      = (is_front(s_scan) == hemi_front_r);
    cur_nxt   = cur_r;
    best_nxt  = best_r;
    start_nxt = start_r;
    if (incl) begin
      if (!valid_r[s_scan]) begin
        cur_nxt = cur_r + 1'b1;
        if (cur_nxt > best_r) begin
          best_nxt  = cur_nxt;
          start_nxt = k_r - cur_r;
        end
      end else begin
        cur_nxt = '0;
      end
    end
  end

  // Dropout decision and per-sector missing mark.
  always_comb begin
    fdrop   = ({front_r, 1'b0} < {1'b0, ((rear_r == '0) ? TOT_W'(1) : rear_r)})
              && (32'(fbest_r) >= 32'(cfg.gap_thr));
    rdrop   = ({rear_r, 1'b0} < {1'b0, ((front_r == '0) ? TOT_W'(1) : front_r)})
              && (32'(best_r) >= 32'(cfg.gap_thr));
    e_sec   = k_r[SECT_W-1:0];
    e_front = is_front(e_sec);
    e_pos   = e_front ? KW'(e_sec) : rear_pos(e_sec);
    in_f    = fdrop_r && e_front && ({1'b0, e_pos} >= {1'b0, fstart_r})
              && ({1'b0, e_pos} < ({1'b0, fstart_r} + {1'b0, fbest_r}));
    in_r    = rdrop_r && !e_front && ({1'b0, e_pos} >= {1'b0, start_r})
              && ({1'b0, e_pos} < ({1'b0, start_r} + {1'b0, best_r}));
  end

  // Sector count memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bins_mem[rd_addr] <= cnt_inc;
    end
    rd_data_r <= bins_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      front_r     <= '0;
      rear_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= valid_r[rd_addr];
      // A new result replaces the one that is leaving in the same cycle.
      if (state_r == ST_EM_OUT && slot_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid && q_item.opcode == OP_EOF) map_r <= q_item.map_count;
        end
        ST_BIN_WR: begin
          valid_r[cord_sector] <= 1'b1;
          if (total_r != TOT_MAX) total_r <= total_r + 1'b1;
          if (is_front(cord_sector)) begin
            if (front_r != TOT_MAX) front_r <= front_r + 1'b1;
          end else if (rear_r != TOT_MAX) begin
            rear_r <= rear_r + 1'b1;
          end
        end
        ST_EOF_SETUP: begin
          m_r       <= m_eff;
          rm_r      <= {{CNT_W{1'b0}}, cfg.ratio} * {{RATIO_W{1'b0}}, m_eff};
          empty_r   <= (total_r == '0);
          partial_r <= 1'b0;
          k_r       <= '0;
        end
        ST_CHK_EV: begin
          if (cnt_rd == '0 || RM_W'({cmin, 8'b0}) < rm_r) partial_r <= 1'b1;
          if (k_last) begin
            k_r          <= '0;
            hemi_front_r <= 1'b1;
            cur_r        <= '0;
            best_r       <= '0;
            start_r      <= '0;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (k_last) begin
            k_r <= '0;
            if (hemi_front_r) begin
              fbest_r      <= best_nxt;
              fstart_r     <= start_nxt;
              hemi_front_r <= 1'b0;
              cur_r        <= '0;
              best_r       <= '0;
              start_r      <= '0;
            end else begin
              best_r  <= best_nxt;
              start_r <= start_nxt;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            cur_r   <= cur_nxt;
            best_r  <= best_nxt;
            start_r <= start_nxt;
          end
        end
        ST_DECIDE: begin
          fdrop_r <= fdrop || empty_r;
          rdrop_r <= rdrop || empty_r;
          if (fdrop || rdrop || empty_r) partial_r <= 1'b1;
          k_r <= '0;
        end
        ST_EM_RD: div_cnt_r <= '0;
        ST_EM_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == '0) begin
            cnt_cur_r <= cnt_rd;
            sat_r     <= (cnt_rd >= m_r);
            rem_r     <= {1'b0, cnt_rd};
            quot_r    <= '0;
          end else if (rem2 >= {1'b0, m_r}) begin
            rem_r  <= rem2 - {1'b0, m_r};
            quot_r <= {quot_r[QUOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem2;
            quot_r <= {quot_r[QUOT_W-2:0], 1'b0};
          end
        end
        ST_EM_OUT: begin
          if (slot_free) begin
            out_res_r.sector_index      <= IDX_W'(e_sec);
            out_res_r.sector_state      <= empty_r || in_f || in_r;
            out_res_r.coverage_q8       <= sat_r ? COV_W'(256) : {1'b0, quot_r};
            out_res_r.sector_points     <= cnt_cur_r;
            out_res_r.frame_incomplete  <= partial_r;
            out_res_r.front_blind       <= fdrop_r;
            out_res_r.rear_blind        <= rdrop_r;
            out_res_r.frame_points      <= total_r;
            out_res_r.map_points        <= map_r;
            out_res_r.last_sector       <= k_last;
            if (k_last) begin
              valid_r <= '0;
              total_r <= '0;
              front_r <= '0;
              rear_r  <= '0;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> dv/lidar_sector_dropout_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR sector dropout detector testbench
// Sends points and end-of-frame items under random idling on both channels.
// Every sector report is checked against an internal bearing and dropout
// predictor. A few empty frames are checked against values that are typed in.
// ----------------------------------------------------------------------------
module lidar_sector_dropout_detector_test;
  import lsdd_pkg::*;

  localparam int RUN_LIMIT = 600000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_opcode = OP_POINT;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic [MAP_W-1:0]          in_map_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [IDX_W-1:0]          out_sector_index;
  logic                      out_sector_state;
  logic [COV_W-1:0]          out_coverage_q8;
  logic [CNT_W-1:0]          out_sector_points;
  logic                      out_frame_incomplete;
  logic                      out_front_blind;
  logic                      out_rear_blind;
  logic [TOT_W-1:0]          out_frame_points;
  logic [MAP_W-1:0]          out_map_points;
  logic                      out_last_sector;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_MIN_POINTS;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  always #1 clk = ~clk;

  lidar_sector_dropout_detector dut (.*);

  // Predictor state: a shadow copy of the sector counters and the registers.
  logic [CNT_W-1:0]   shadow_hits [SECTORS];
  logic [TOT_W-1:0]   shadow_total, shadow_front, shadow_rear;
  logic [CNT_W-1:0]   shadow_min_points;
  logic [RATIO_W-1:0] shadow_ratio;
  logic [THR_W-1:0]   shadow_gap_thr;

  // Sector reports that are owed by the block, oldest first.
  result_t sector_reports_due [$];

  int errors = 0;
  int cycles = 0;
  bit hold_armed = 0;

  // Angles of the CORDIC micro-rotations, in 2^-32 turn units.
  logic [31:0] rot_angle [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  // Bearing plus pi, in 2^-32 turn units, exactly as the angle unit rounds it.
  function automatic logic [31:0] bearing_turns(longint x, longint y);
    longint cx, cy, dx, dy;
    logic [31:0] acc, u;
    if (y == 0) return (x < 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
    cx = x * 65536;
    cy = y * 65536;
    acc = '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += rot_angle[i];
      end else begin
        cx -= dx; cy += dy; acc -= rot_angle[i];
      end
    end
    u = acc + 32'h8000_0000;
    // Keep the result in the half plane that the sign of y names.
    if (y > 0 && u <= 32'h8000_0000) u = (u < 32'h4000_0000) ? 32'hFFFF_FFFF : 32'h8000_0001;
    if (y < 0 && u >= 32'h8000_0000) u = (u >= 32'hC000_0000) ? 32'h0 : 32'h7FFF_FFFF;
    return u;
  endfunction

  function automatic bit faces_front(int s);
    int d;
    d = 4 * s + 2 - 2 * SECTORS;
    if (d < 0) d = -d;
    return d <= SECTORS;
  endfunction

  // Scan order of one hemisphere; the rear one is walked across +-pi.
  function automatic int scan_order(bit front, ref int order [SECTORS]);
    int n;
    n = 0;
    for (int s = 0; s < SECTORS; s++)
      if (front ? faces_front(s) : (!faces_front(s) && 2 * s + 1 > SECTORS)) order[n++] = s;
    if (!front)
      for (int s = 0; s < SECTORS; s++)
        if (!faces_front(s) && 2 * s + 1 <= SECTORS) order[n++] = s;
    return n;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_hits[s]) shadow_hits[s] = '0;
    shadow_total = '0;
    shadow_front = '0;
    shadow_rear = '0;
  endfunction

  // Takes one accepted item into the shadow state; an end of frame queues the
  // sector reports. With typed_empty set the reports of an empty frame are
  // written out by hand instead of taken from the prediction.
  function automatic void account_item(logic op, logic signed [15:0] x, logic signed [15:0] y,
                                       logic [MAP_W-1:0] mapc, bit typed_empty);
    logic [31:0] u;
    int s, n, run, best, start, m;
    int order [SECTORS];
    bit missing [SECTORS];
    bit partial, fdrop, rdrop, front;
    longint mine, other, c, cov;
    result_t r;
    if (op == OP_POINT) begin
      u = bearing_turns(x, y);
      s = ((u >> 16) * SECTORS) >> 16;
      if (s >= SECTORS) s = SECTORS - 1;
      if (shadow_hits[s] != CNT_MAX) shadow_hits[s]++;
      if (shadow_total != TOT_MAX) shadow_total++;
      if (faces_front(s)) begin
        if (shadow_front != TOT_MAX) shadow_front++;
      end else if (shadow_rear != TOT_MAX) begin
        shadow_rear++;
      end
      return;
    end
    m = (shadow_min_points == 0) ? 1 : int'(shadow_min_points);
    partial = 0; fdrop = 0; rdrop = 0;
    foreach (missing[k]) missing[k] = 0;
    if (shadow_total == 0) begin
      partial = 1; fdrop = 1; rdrop = 1;
      foreach (missing[k]) missing[k] = 1;
    end else begin
      for (int k = 0; k < SECTORS; k++) begin
        c = (shadow_hits[k] < m) ? shadow_hits[k] : m;
        if (shadow_hits[k] == 0 || c * 256 < longint'(shadow_ratio) * m) partial = 1;
      end
      for (int h = 0; h < 2; h++) begin
        front = (h == 0);
        mine  = front ? shadow_front : shadow_rear;
        other = front ? shadow_rear : shadow_front;
        n = scan_order(front, order);
        best = 0; run = 0; start = 0;
        for (int i = 0; i < n; i++) begin
          if (shadow_hits[order[i]] == 0) begin
            run++;
            if (run > best) begin
              best = run;
              start = i + 1 - run;
            end
          end else begin
            run = 0;
          end
        end
        if (mine * 2 < ((other != 0) ? other : 1) && best >= shadow_gap_thr) begin
          partial = 1;
          if (front) fdrop = 1; else rdrop = 1;
          for (int k = 0; k < best; k++) missing[order[start + k]] = 1;
        end
      end
    end
    for (int k = 0; k < SECTORS; k++) begin
      cov = (longint'(shadow_hits[k]) * 256) / m;
      r.sector_index     = IDX_W'(k);
      r.sector_state     = missing[k];
      r.coverage_q8      = COV_W'((cov > 256) ? 256 : cov);
      r.sector_points    = shadow_hits[k];
      r.frame_incomplete = partial;
      r.front_blind      = fdrop;
      r.rear_blind       = rdrop;
      r.frame_points     = shadow_total;
      r.map_points       = mapc;
      r.last_sector      = (k == SECTORS - 1);
      if (typed_empty) begin
        // An empty frame reports every sector missing with all flags raised.
        r = '{sector_index: IDX_W'(k), sector_state: 1'b1, coverage_q8: '0,
              sector_points: '0, frame_incomplete: 1'b1, front_blind: 1'b1,
              rear_blind: 1'b1, frame_points: '0, map_points: mapc,
              last_sector: (k == SECTORS - 1)};
      end
      sector_reports_due.insert(sector_reports_due.size(), r);
    end
    clear_shadow();
  endfunction

  task automatic check_field(string name, longint exp, longint act);
    if (exp != act) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp, act);
    end
  endtask

  // Result side: checks each transfer and stalls at random. A long hold-off
  // can be armed by the stimulus so that the input queue fills up.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    result_t e;
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sector_reports_due.size() == 0) begin
          errors++;
          $display("%0t unexpected sector report: expected none, actual sector %0d",
                   $time, out_sector_index);
        end else begin
          e = sector_reports_due.pop_front();
          check_field("sector_index", e.sector_index, out_sector_index);
          check_field("sector_state", e.sector_state, out_sector_state);
          check_field("coverage_q8", e.coverage_q8, out_coverage_q8);
          check_field("sector_points", e.sector_points, out_sector_points);
          check_field("frame_incomplete", e.frame_incomplete, out_frame_incomplete);
          check_field("front_blind", e.front_blind, out_front_blind);
          check_field("rear_blind", e.rear_blind, out_rear_blind);
          check_field("frame_points", e.frame_points, out_frame_points);
          check_field("map_points", e.map_points, out_map_points);
          check_field("last_sector", e.last_sector, out_last_sector);
        end
      end
      if (hold_armed) begin
        hold_armed = 0;
        hold_left = 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        case ($urandom_range(0, 19))
          0, 1:    stall_left = $urandom_range(1, 3);
          2:       stall_left = $urandom_range(10, 50);
          default: stall_left = 0;
        endcase
      end
    end
  end

  bit steady_send = 0;

  // Offers one item and waits for its transfer, then sometimes idles for a while.
  task automatic send_item(logic op, logic signed [15:0] x, logic signed [15:0] y,
                           logic [MAP_W-1:0] mapc, bit typed_empty = 0);
    int gap;
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_point_x   <= x;
    in_point_y   <= y;
    in_map_count <= mapc;
    do @(posedge clk); while (in_stall);
    account_item(op, x, y, mapc, typed_empty);
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = $urandom_range(15, 40);
      default: gap = 0;
    endcase
    if (steady_send) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every owed report has come, then lets the engine settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sector_reports_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] min_points, logic [8:0] ratio, logic [6:0] thr);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_POINTS;
    cfg_wdata <= min_points;
    @(posedge clk);
    cfg_index <= CFG_PARTIAL_RATIO;
    cfg_wdata <= CFG_W'(ratio);
    @(posedge clk);
    cfg_index <= CFG_GAP_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_min_points = min_points;
    shadow_ratio = ratio;
    shadow_gap_thr = thr;
  endtask

  // One frame of random points, shaped so that dropouts show up often.
  task automatic send_frame();
    int style, npts;
    logic signed [15:0] x, y;
    style = $urandom_range(0, 5);
    npts = (style == 5) ? 0 : $urandom_range(1, 14);
    steady_send = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < npts; i++) begin
      x = 16'($urandom);
      y = 16'($urandom);
      case (style)
        1: x = 16'($urandom_range(1, 32767));
        2: x = 16'(-$signed(17'($urandom_range(1, 32768))));
        3: begin
          x = $signed(16'($urandom_range(0, 15))) - 16'sd8;
          y = $signed(16'($urandom_range(0, 15))) - 16'sd8;
        end
        4: if ($urandom_range(0, 1)) y = 0; else x = 0;
        default: ;
      endcase
      send_item(OP_POINT, x, y, MAP_W'($urandom));
    end
    send_item(OP_EOF, 16'($urandom), 16'($urandom), MAP_W'($urandom));
    steady_send = 0;
  endtask

  typedef struct {
    logic               op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [MAP_W-1:0]   mapc;
    bit                 typed_empty;
  } stim_row_t;

  // Directed rows: empty frames after reset, then the axes, the corners and
  // the points right beside +-pi, then a frame seen only ahead and one only
  // behind, which starve the other hemisphere.
  stim_row_t directed [] = '{
    '{OP_EOF,   16'sd0,      16'sd0,      20'h00000, 1'b1},
    '{OP_EOF,   16'sd0,      16'sd0,      20'hFFFFF, 1'b1},
    '{OP_POINT, 16'sd32767,  16'sd0,      20'h0,     1'b0},
    '{OP_POINT, -16'sd32768, 16'sd0,      20'hFFFFF, 1'b0},
    '{OP_POINT, 16'sd0,      16'sd0,      20'h0,     1'b0},
    '{OP_POINT, 16'sd0,      16'sd32767,  20'h0,     1'b0},
    '{OP_POINT, 16'sd0,      -16'sd32768, 20'h0,     1'b0},
    '{OP_POINT, -16'sd32768, 16'sd32767,  20'h0,     1'b0},
    '{OP_POINT, -16'sd32768, -16'sd32768, 20'h0,     1'b0},
    '{OP_POINT, 16'sd32767,  16'sd32767,  20'h0,     1'b0},
    '{OP_POINT, 16'sd32767,  -16'sd32768, 20'h0,     1'b0},
    '{OP_POINT, -16'sd1,     16'sd1,      20'h0,     1'b0},
    '{OP_POINT, -16'sd1,     -16'sd1,     20'h0,     1'b0},
    '{OP_POINT, 16'sd1,      -16'sd1,     20'h0,     1'b0},
    '{OP_POINT, -16'sd32768, 16'sd1,      20'h0,     1'b0},
    '{OP_POINT, -16'sd32768, -16'sd1,     20'h0,     1'b0},
    '{OP_EOF,   16'sd0,      16'sd0,      20'd12345, 1'b0},
    '{OP_POINT, 16'sd1000,   16'sd5,      20'h0,     1'b0},
    '{OP_POINT, 16'sd1000,   -16'sd5,     20'h0,     1'b0},
    '{OP_POINT, 16'sd500,    16'sd400,    20'h0,     1'b0},
    '{OP_EOF,   16'sd0,      16'sd0,      20'h55555, 1'b0},
    '{OP_POINT, -16'sd1000,  16'sd3,      20'h0,     1'b0},
    '{OP_POINT, -16'sd1000,  -16'sd3,     20'h0,     1'b0},
    '{OP_POINT, -16'sd700,   16'sd600,    20'h0,     1'b0},
    '{OP_EOF,   16'sd0,      16'sd0,      20'hAAAAA, 1'b0}
  };

  initial begin
    clear_shadow();
    shadow_min_points = 16'd10;
    shadow_ratio = 9'd128;
    shadow_gap_thr = 7'd3;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].op, directed[i].x, directed[i].y, directed[i].mapc,
                directed[i].typed_empty);
    drain();

    // Settings walk through the extremes first, then random middle values.
    for (int phase = 1; phase <= 7; phase++) begin
      case (phase)
        1:       write_config(16'd0, 9'd0, 7'd0);
        2:       write_config(16'hFFFF, 9'd256, 7'd64);
        3:       write_config(16'd1, 9'd256, 7'd1);
        default: write_config(16'($urandom_range(0, 20)), 9'($urandom_range(0, 256)),
                              7'($urandom_range(0, 12)));
      endcase
      // In one phase the result side holds off for a long time while the
      // frames keep coming, so the input side must stall.
      if (phase == 4) hold_armed = 1;
      repeat ($urandom_range(2, 3)) send_frame();
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
